>>> rtl/mmfm_pkg.sv
// Shared types and constants for the map element to float converter.
package mmfm_pkg;

    // Data that rides alongside the arithmetic: a finished value that skips
    // the remaining stages, and the buffer-end flag.
    typedef struct packed {
        logic        byp;
        logic [31:0] bval;
        logic        last;
    } t_side;

    localparam logic [2:0]  MODE_BYTE    = 3'd0;
    localparam logic [2:0]  MODE_USHORT  = 3'd1;
    localparam logic [2:0]  MODE_CUSHORT = 3'd3;
    localparam logic [2:0]  MODE_CFLOAT  = 3'd4;

    localparam logic [31:0] FLT_PINF  = 32'h7F80_0000;
    localparam logic [31:0] FLT_QUIET = 32'h0040_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

endpackage

>>> rtl/mmfm_sqrt.sv
// Pipelined correctly rounded square root of a non-negative single.
module mmfm_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_s,
    input  mmfm_pkg::t_side      i_side,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_float_value,
    output logic                 o_last_out
);

    localparam int SQ_STG = 5;               // recurrence stages
    localparam int SQ_PER = 5;               // root bits per stage
    localparam int NS     = SQ_STG + 2;      // prep + recurrence + round

    typedef struct packed {
        logic [27:0] rem;
        logic [24:0] root;
        logic [49:0] x;
    } t_sq;

    function automatic t_sq sqrt_steps(input t_sq s_in);
        t_sq         s;
        logic [27:0] r2;
        logic [27:0] t;
        s = s_in;
        for (int i = 0; i < SQ_PER; i++) begin
            r2 = {s.rem[25:0], s.x[49:48]};
            t  = {1'b0, s.root, 2'b01};
            if (r2 >= t) begin
                s.rem  = r2 - t;
                s.root = {s.root[23:0], 1'b1};
            end else begin
                s.rem  = r2;
                s.root = {s.root[23:0], 1'b0};
            end
            s.x = {s.x[47:0], 2'b00};
        end
        return s;
    endfunction

    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   en;
    t_sq             r_st   [0:SQ_STG];
    t_sq             n_st   [1:SQ_STG];
    logic [7:0]      r_rexp [0:SQ_STG];
    mmfm_pkg::t_side r_side [0:SQ_STG];
    logic [31:0]     r_o_val;
    logic            r_o_last;

    // prep stage signals
    logic [7:0]        w_ex;
    logic [22:0]       w_fr;
    logic [4:0]        w_p;
    logic [4:0]        w_lz;
    logic [23:0]       w_m;
    logic signed [9:0] w_e;
    logic signed [9:0] w_diff;
    logic signed [9:0] w_rexp;
    t_sq               n_st0;
    mmfm_pkg::t_side   n_side0;

    // round stage signals
    logic [23:0] w_sig;
    logic        w_inc;
    logic [31:0] n_o_val;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        w_ex = i_s[30:23];
        w_fr = i_s[22:0];
        w_p  = '0;
        for (int i = 0; i < 23; i++) begin
            if (w_fr[i]) begin
                w_p = 5'(i);
            end
        end
        w_lz = 5'd23 - w_p;
        if (w_ex == 8'd0) begin
            w_m = 24'(w_fr) << w_lz;
            w_e = -10'sd149 - 10'(w_lz);
        end else begin
            w_m = {1'b1, w_fr};
            w_e = 10'({2'b00, w_ex}) - 10'sd150;
        end
        // keep the exponent of the radicand even
        if (w_e[0]) begin
            n_st0.x = {1'b0, w_m, 25'd0};
            w_diff  = w_e - 10'sd25;
        end else begin
            n_st0.x = {w_m, 26'd0};
            w_diff  = w_e - 10'sd26;
        end
        n_st0.rem  = '0;
        n_st0.root = '0;
        w_rexp     = 10'sd151 + (w_diff >>> 1);
        n_side0    = i_side;
        if (!i_side.byp) begin
            if (i_s[30:0] == 31'd0) begin
                n_side0.byp  = 1'b1;
                n_side0.bval = '0;
            end else if (w_ex == mmfm_pkg::EXP_MAX) begin
                n_side0.byp  = 1'b1;
                n_side0.bval = mmfm_pkg::FLT_PINF;
            end
        end
    end

    always_comb begin
        for (int k = 1; k <= SQ_STG; k++) begin
            n_st[k] = sqrt_steps(r_st[k-1]);
        end
    end

    always_comb begin
        w_sig = r_st[SQ_STG].root[24:1];
        w_inc = r_st[SQ_STG].root[0] & ((|r_st[SQ_STG].rem) | w_sig[0]);
        if (r_side[SQ_STG].byp) begin
            n_o_val = r_side[SQ_STG].bval;
        end else begin
            n_o_val = {1'b0, r_rexp[SQ_STG], w_sig[22:0]} + {31'd0, w_inc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_st[0]   <= n_st0;
            r_rexp[0] <= w_rexp[7:0];
            r_side[0] <= n_side0;
        end
        for (int k = 1; k <= SQ_STG; k++) begin
            if (en[k]) begin
                r_st[k]   <= n_st[k];
                r_rexp[k] <= r_rexp[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
        if (en[NS-1]) begin
            r_o_val  <= n_o_val;
            r_o_last <= r_side[SQ_STG].last;
        end
    end

    assign o_valid       = r_vld[NS-1];
    assign o_float_value = r_o_val;
    assign o_last_out    = r_o_last;

endmodule

>>> rtl/map_mode_to_float_magnitude_core.sv
// Top level: map element to single precision, with complex magnitude.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_valid / o_stall          | i_real_part, i_imag_part, i_last_element
//  output   | o_valid / i_stall          | o_float_value, o_last_out
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (element mode)
//
// One beat per cycle while the output is not stalled; 7 stages here for convert,
// square, add and round, 7 in the root unit: 5 stages of 5 root bits each.
// Beats in undefined modes are taken and dropped at the first stage.
// Synchronous active-low reset clears valid bits and the mode register.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up under output stall and no beat is lost or repeated.
module map_mode_to_float_magnitude_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_real_part,
    input  logic [31:0] i_imag_part,
    input  logic        i_last_element,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_float_value,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    localparam int TS = 7;

    function automatic logic [31:0] u16_to_float(input logic [15:0] v);
        logic [4:0]  p;
        logic [23:0] m;
        logic [31:0] r;
        p = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        m = 24'(v) << (5'd23 - p);
        if (v == 16'd0) begin
            r = '0;
        end else begin
            r = {1'b0, 8'd127 + {3'd0, p}, m[22:0]};
        end
        return r;
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == mmfm_pkg::EXP_MAX) && (f[22:0] != 23'd0);
    endfunction

    // Round a value pn * 2^(bexp-127-47), leading one at bit 47, to nearest
    // even; handles gradual underflow and overflow to infinity.
    function automatic logic [31:0] round_pack(input logic signed [10:0] bexp,
                                               input logic [47:0] pn);
        logic [47:0] sh;
        logic        lost;
        logic [5:0]  d;
        logic [7:0]  ef;
        logic [23:0] sig;
        logic        inc;
        logic [31:0] r;
        sh   = pn;
        lost = 1'b0;
        ef   = bexp[7:0];
        d    = '0;
        if (bexp <= 11'sd0) begin
            ef = '0;
            if (bexp < -11'sd47) begin
                sh   = '0;
                lost = |pn;
            end else begin
                d    = 6'(11'sd1 - bexp);
                sh   = pn >> d;
                lost = |(pn & ((48'd1 << d) - 48'd1));
            end
        end
        sig = sh[47:24];
        inc = sh[23] & ((|sh[22:0]) | lost | sig[0]);
        if (bexp >= 11'sd255) begin
            r = mmfm_pkg::FLT_PINF;
        end else begin
            // a carry out of the fraction lifts the exponent field
            r = {1'b0, ef, sig[22:0]} + {31'd0, inc};
        end
        return r;
    endfunction

    function automatic logic [31:0] sq_round(input logic [47:0] prod,
                                             input logic [7:0] ex);
        logic [47:0]       pn;
        logic signed [10:0] be;
        logic [31:0]       r;
        pn = prod[47] ? prod : {prod[46:0], 1'b0};
        be = 11'({2'b00, ex, 1'b0}) - 11'sd127 + 11'(prod[47]);
        if (ex == mmfm_pkg::EXP_MAX) begin
            r = mmfm_pkg::FLT_PINF;
        end else if (ex == 8'd0) begin
            r = '0;           // subnormal squared is far below half the least step
        end else begin
            r = round_pack(be, pn);
        end
        return r;
    endfunction

    logic [2:0]      r_mode;
    logic [TS-1:0]   r_vld;
    logic [TS-1:0]   en;
    logic            w_mode_ok;
    logic            w_sq_stall;
    mmfm_pkg::t_side r_side [1:TS-1];

    // stage 0
    logic [2:0]  r_a_mode;
    logic [31:0] r_a_re;
    logic [31:0] r_a_im;
    logic        r_a_last;
    // stage 1
    logic [31:0]     r_b_fa;
    logic [31:0]     r_b_fb;
    logic [31:0]     n_b_fa;
    logic [31:0]     n_b_fb;
    mmfm_pkg::t_side n_b_side;
    // stage 2
    logic [23:0] w_ma;
    logic [23:0] w_mb;
    logic [47:0] w_prod_a;
    logic [47:0] w_prod_b;
    logic [47:0] r_c_prod_a;
    logic [47:0] r_c_prod_b;
    logic [7:0]  r_c_ea;
    logic [7:0]  r_c_eb;
    // stage 3
    logic [31:0] r_d_pa;
    logic [31:0] r_d_pb;
    // stage 4
    logic [31:0] w_big;
    logic [31:0] w_small;
    logic [7:0]  w_eb;
    logic [7:0]  w_d;
    logic [47:0] w_bw;
    logic [23:0] n_e_ma;
    logic [47:0] n_e_sh;
    logic        n_e_st;
    logic        n_e_spec;
    logic [31:0] n_e_sval;
    logic [23:0] r_e_ma;
    logic [47:0] r_e_sh;
    logic        r_e_st;
    logic [7:0]  r_e_exp;
    logic        r_e_spec;
    logic [31:0] r_e_sval;
    // stage 5
    logic [48:0] w_sum;
    logic [47:0] n_f_pn;
    logic [8:0]  n_f_bexp;
    logic [47:0] r_f_pn;
    logic [8:0]  r_f_bexp;
    logic        r_f_spec;
    logic [31:0] r_f_sval;
    // stage 6
    logic [31:0] n_r_s;
    logic [31:0] r_r_s;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mmfm_pkg::MODE_BYTE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    assign w_mode_ok = (r_mode == mmfm_pkg::MODE_BYTE)    ||
                       (r_mode == mmfm_pkg::MODE_USHORT)  ||
                       (r_mode == mmfm_pkg::MODE_CUSHORT) ||
                       (r_mode == mmfm_pkg::MODE_CFLOAT);

    always_comb begin
        en[TS-1] = !r_vld[TS-1] || !w_sq_stall;
        for (int k = TS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    // stage 1: unpack per mode
    always_comb begin
        n_b_side.byp  = 1'b0;
        n_b_side.bval = '0;
        n_b_side.last = r_a_last;
        n_b_fa        = '0;
        n_b_fb        = '0;
        case (r_a_mode)
            mmfm_pkg::MODE_BYTE: begin
                n_b_side.byp  = 1'b1;
                n_b_side.bval = u16_to_float({8'd0, r_a_re[7:0]});
            end
            mmfm_pkg::MODE_USHORT: begin
                n_b_side.byp  = 1'b1;
                n_b_side.bval = u16_to_float(r_a_re[15:0]);
            end
            mmfm_pkg::MODE_CUSHORT: begin
                n_b_fa = u16_to_float(r_a_re[15:0]);
                n_b_fb = u16_to_float(r_a_im[15:0]);
            end
            mmfm_pkg::MODE_CFLOAT: begin
                if (is_nan(r_a_re)) begin
                    n_b_side.byp  = 1'b1;
                    n_b_side.bval = r_a_re | mmfm_pkg::FLT_QUIET;
                end else if (is_nan(r_a_im)) begin
                    n_b_side.byp  = 1'b1;
                    n_b_side.bval = r_a_im | mmfm_pkg::FLT_QUIET;
                end
                n_b_fa = {1'b0, r_a_re[30:0]};
                n_b_fb = {1'b0, r_a_im[30:0]};
            end
            default: begin
                n_b_side.byp = 1'b0;
            end
        endcase
    end

    // stage 2: significand squares
    assign w_ma     = {1'b1, r_b_fa[22:0]};
    assign w_mb     = {1'b1, r_b_fb[22:0]};
    assign w_prod_a = w_ma * w_ma;
    assign w_prod_b = w_mb * w_mb;

    // stage 4: order and align the two squares
    always_comb begin
        if (r_d_pa[30:0] >= r_d_pb[30:0]) begin
            w_big   = r_d_pa;
            w_small = r_d_pb;
        end else begin
            w_big   = r_d_pb;
            w_small = r_d_pa;
        end
        w_eb     = (w_small[30:23] == 8'd0) ? 8'd1 : w_small[30:23];
        w_d      = w_big[30:23] - w_eb;
        w_bw     = {(w_small[30:23] != 8'd0), w_small[22:0], 24'd0};
        n_e_ma   = {1'b1, w_big[22:0]};
        n_e_spec = 1'b0;
        n_e_sval = '0;
        if (w_d >= 8'd48) begin
            n_e_sh = '0;
            n_e_st = |w_bw;
        end else begin
            n_e_sh = w_bw >> w_d[5:0];
            n_e_st = |(w_bw & ((48'd1 << w_d[5:0]) - 48'd1));
        end
        if ((r_d_pa[30:23] == mmfm_pkg::EXP_MAX) || (r_d_pb[30:23] == mmfm_pkg::EXP_MAX)) begin
            n_e_spec = 1'b1;
            n_e_sval = mmfm_pkg::FLT_PINF;
        end else if (w_big[30:23] == 8'd0) begin
            // both subnormal: the plain sum of the encodings is exact
            n_e_spec = 1'b1;
            n_e_sval = {1'b0, w_big[30:0] + w_small[30:0]};
        end
    end

    // stage 5: add and normalise
    always_comb begin
        w_sum = {1'b0, r_e_ma, 24'd0} + {1'b0, r_e_sh};
        if (w_sum[48]) begin
            n_f_pn   = {w_sum[48:2], w_sum[1] | w_sum[0] | r_e_st};
            n_f_bexp = {1'b0, r_e_exp} + 9'd1;
        end else begin
            n_f_pn   = {w_sum[47:1], w_sum[0] | r_e_st};
            n_f_bexp = {1'b0, r_e_exp};
        end
    end

    // stage 6: round the sum
    assign n_r_s = r_f_spec ? r_f_sval : round_pack(11'({2'b00, r_f_bexp}), r_f_pn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid && w_mode_ok;
            end
            for (int k = 1; k < TS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_mode <= r_mode;
            r_a_re   <= i_real_part;
            r_a_im   <= i_imag_part;
            r_a_last <= i_last_element;
        end
        if (en[1]) begin
            r_b_fa    <= n_b_fa;
            r_b_fb    <= n_b_fb;
            r_side[1] <= n_b_side;
        end
        if (en[2]) begin
            r_c_prod_a <= w_prod_a;
            r_c_prod_b <= w_prod_b;
            r_c_ea     <= r_b_fa[30:23];
            r_c_eb     <= r_b_fb[30:23];
            r_side[2]  <= r_side[1];
        end
        if (en[3]) begin
            r_d_pa    <= sq_round(r_c_prod_a, r_c_ea);
            r_d_pb    <= sq_round(r_c_prod_b, r_c_eb);
            r_side[3] <= r_side[2];
        end
        if (en[4]) begin
            r_e_ma    <= n_e_ma;
            r_e_sh    <= n_e_sh;
            r_e_st    <= n_e_st;
            r_e_exp   <= w_big[30:23];
            r_e_spec  <= n_e_spec;
            r_e_sval  <= n_e_sval;
            r_side[4] <= r_side[3];
        end
        if (en[5]) begin
            r_f_pn    <= n_f_pn;
            r_f_bexp  <= n_f_bexp;
            r_f_spec  <= r_e_spec;
            r_f_sval  <= r_e_sval;
            r_side[5] <= r_side[4];
        end
        if (en[6]) begin
            r_r_s     <= n_r_s;
            r_side[6] <= r_side[5];
        end
    end

    mmfm_sqrt u_sqrt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_vld[TS-1]),
        .o_stall       (w_sq_stall),
        .i_s           (r_r_s),
        .i_side        (r_side[TS-1]),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_float_value (o_float_value),
        .o_last_out    (o_last_out)
    );

`ifndef ASSERT_OFF
    a_drop_bad_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !w_mode_ok |=> !r_vld[0])
        else $error("beat in undefined mode entered the pipe");

    a_hold_into_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TS-1] && w_sq_stall |=> r_vld[TS-1] && $stable(r_r_s) &&
                                      $stable(r_side[TS-1]))
        else $error("beat into root unit lost or changed under stall");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_mode == $past(i_cfg_data))
        else $error("mode register write not taken");
`endif

endmodule

>>> tb/map_mode_to_float_magnitude_core_tb.sv
// Testbench for the map element to float converter, with its own float arithmetic model.
`timescale 1ns / 100ps

module map_mode_to_float_magnitude_core_tb;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } t_elem;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } t_conv;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_real_part = '0;
    logic [31:0] i_imag_part = '0;
    logic        i_last_element = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_float_value;
    logic        o_last_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;

    t_elem       elem_q[$];
    t_conv       conv_q[$];
    logic [2:0]  cur_mode = mmfm_pkg::MODE_BYTE;
    int          errors = 0;
    int          profile = 0;
    int          quiet_cycles = 0;

    // the undefined modes, each visited once before the random part
    logic [2:0] m_list[4] = '{3'd2, 3'd5, 3'd6, 3'd7};

    map_mode_to_float_magnitude_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_real_part    (i_real_part),
        .i_imag_part    (i_imag_part),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_float_value  (o_float_value),
        .o_last_out     (o_last_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Round the exact value m * 2^e to single precision, nearest-even,
    // with gradual underflow and overflow to +inf.
    function automatic logic [31:0] fp_round(logic [127:0] m, int e);
        int nb;
        int sh;
        int lsb;
        logic [127:0] sig;
        logic g;
        logic st;
        if (m == 0) return 32'd0;
        nb = 0;
        for (int i = 0; i < 128; i++) if (m[i]) nb = i + 1;
        sh = nb - 24;
        if (e + sh < -149) sh = -149 - e;
        if (sh >= 128) return 32'd0;
        if (sh <= 0) begin
            sig = m << (-sh);
        end else begin
            sig = m >> sh;
            g   = m[sh-1];
            st  = (m & ((128'd1 << (sh - 1)) - 1)) != 0;
            if (g && (st || sig[0])) sig = sig + 1;
        end
        lsb = e + sh;
        if (lsb + 149 + int'(sig >> 23) >= 255) return mmfm_pkg::FLT_PINF;
        return 32'((lsb + 149) << 23) + sig[31:0];
    endfunction

    function automatic void fp_split(input logic [31:0] f, output logic [63:0] m,
                                     output int e);
        if (f[30:23] == 8'd0) begin
            m = {41'd0, f[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, f[22:0]};
            e = int'(f[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] fp_square(logic [31:0] f);
        logic [63:0] m;
        int e;
        if (f[30:23] == mmfm_pkg::EXP_MAX) return mmfm_pkg::FLT_PINF;
        fp_split(f, m, e);
        return fp_round(128'(m * m), 2 * e);
    endfunction

    // Both operands are non-negative squares.
    function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma, mb, mt;
        int ea, eb, et, d;
        if (a[30:23] == mmfm_pkg::EXP_MAX || b[30:23] == mmfm_pkg::EXP_MAX)
            return mmfm_pkg::FLT_PINF;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        if (ma == 0) return fp_round(128'(mb), eb);
        if (mb == 0) return fp_round(128'(ma), ea);
        if (eb > ea) begin
            mt = ma; ma = mb; mb = mt;
            et = ea; ea = eb; eb = et;
        end
        d = ea - eb;
        // far apart: the small one only sets a sticky bit
        if (d > 36) return fp_round((128'(ma) << 3) | 128'd1, ea - 3);
        return fp_round((128'(ma) << d) + 128'(mb), eb);
    endfunction

    function automatic logic [31:0] fp_root(logic [31:0] s);
        logic [63:0] m, x, r, bitv;
        int e;
        if (s[30:0] == 31'd0) return 32'd0;
        if (s[30:23] == mmfm_pkg::EXP_MAX) return mmfm_pkg::FLT_PINF;
        fp_split(s, m, e);
        if (e % 2 != 0) begin
            m = m << 1;
            e = e - 1;
        end
        while (m < (64'd1 << 50)) begin
            m = m << 2;
            e = e - 2;
        end
        x = m;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return fp_round({63'd0, r, x != 0}, e / 2 - 1);
    endfunction

    function automatic logic [31:0] magnitude_of(logic [31:0] a, logic [31:0] b);
        return fp_root(fp_sum(fp_square(a), fp_square(b)));
    endfunction

    function automatic logic is_nan(logic [31:0] f);
        return f[30:23] == mmfm_pkg::EXP_MAX && f[22:0] != 23'd0;
    endfunction

    function automatic logic convert_elem(input t_elem it, input logic [2:0] mode,
                                          output t_conv res);
        res.last = it.last;
        case (mode)
            mmfm_pkg::MODE_BYTE:    res.value = fp_round(128'(it.re[7:0]), 0);
            mmfm_pkg::MODE_USHORT:  res.value = fp_round(128'(it.re[15:0]), 0);
            mmfm_pkg::MODE_CUSHORT: res.value = magnitude_of(fp_round(128'(it.re[15:0]), 0),
                                                             fp_round(128'(it.im[15:0]), 0));
            mmfm_pkg::MODE_CFLOAT: begin
                if (is_nan(it.re))      res.value = it.re | mmfm_pkg::FLT_QUIET;
                else if (is_nan(it.im)) res.value = it.im | mmfm_pkg::FLT_QUIET;
                else                    res.value = magnitude_of(it.re, it.im);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic int send_idle_pct();
        return profile == 0 ? 6 : (profile == 1 ? 72 : 0);
    endfunction

    function automatic int recv_idle_pct();
        return profile == 0 ? 72 : (profile == 1 ? 6 : 0);
    endfunction

    // driver: one beat per accepted handshake, predicting as it goes
    always @(posedge i_clk) begin
        t_conv c;
        t_elem it;
        logic  acc;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            acc = i_valid && !o_stall;
            if (acc) begin
                it.re = i_real_part;
                it.im = i_imag_part;
                it.last = i_last_element;
                if (convert_elem(it, cur_mode, c)) conv_q.push_back(c);
            end
            if (!i_valid || acc) begin
                if (elem_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    it = elem_q.pop_front();
                    i_valid        <= 1'b1;
                    i_real_part    <= it.re;
                    i_imag_part    <= it.im;
                    i_last_element <= it.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_conv w;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (conv_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_float_value, 32'd0);
                end else begin
                    w = conv_q.pop_front();
                    if (o_float_value !== w.value)
                        report_mismatch("float_value", o_float_value, w.value);
                    if (o_last_out !== w.last)
                        report_mismatch("last_out", {31'd0, o_last_out}, {31'd0, w.last});
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct());
        end
    end

    // watchdog on cycles with outstanding work but no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || (elem_q.size() == 0 && conv_q.size() == 0 && !i_valid && !i_cfg_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("map_mode_to_float_magnitude_core_tb: errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (elem_q.size() != 0 || conv_q.size() != 0 || i_valid) @(posedge i_clk);
        // dropped beats give no result, so let the pipe drain
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [2:0] m);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_elem(logic [31:0] re, logic [31:0] im, logic last);
        t_elem it;
        it.re = re;
        it.im = im;
        it.last = last;
        elem_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(9))
            0, 1: ;
            2, 3, 4, 5: f[30:23] = 8'($urandom_range(100, 154));
            6: f[30:23] = 8'd0;
            7: f[30:23] = 8'($urandom_range(200, 254));
            8: begin
                f[30:23] = mmfm_pkg::EXP_MAX;
                if ($urandom_range(1)) f[22:0] = 23'd0;
            end
            default: f[30:23] = 8'($urandom_range(0, 30));
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rand_short_part();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: v[15:0] = 16'($urandom_range(0, 255));
            1: v[15:0] = 16'hFFFF - 16'($urandom_range(0, 255));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [2:0] m;
        int n;
        int sent;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset mode is byte
        add_elem(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_elem(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        add_elem(32'h0000_0180, 32'h1234_5678, 1'b0);
        write_mode(mmfm_pkg::MODE_USHORT);
        add_elem(32'hFFFF_FFFF, 32'h0, 1'b1);
        add_elem(32'hABCD_0001, 32'hFFFF_FFFF, 1'b0);
        write_mode(mmfm_pkg::MODE_CUSHORT);
        add_elem(32'h0, 32'h0, 1'b0);
        add_elem(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_elem(32'h0003_0003, 32'h0000_0004, 1'b0);
        add_elem(32'h0000_FFFF, 32'h0000_0001, 1'b0);
        write_mode(mmfm_pkg::MODE_CFLOAT);
        add_elem(32'h8000_0000, 32'h0000_0000, 1'b0);          // signed zeros
        add_elem(32'h3F80_0000, 32'h0000_0000, 1'b1);
        add_elem(32'h7F80_0000, 32'h3F80_0000, 1'b0);          // inf component
        add_elem(32'h3F80_0000, 32'hFF80_0000, 1'b0);
        add_elem(32'hFFA0_0001, 32'h7FC0_0000, 1'b1);          // both NaN, real wins
        add_elem(32'h4040_0000, 32'h7F81_2345, 1'b0);          // signalling NaN in imag
        add_elem(32'h7F7F_FFFF, 32'h0000_0000, 1'b0);          // square overflows
        add_elem(32'h5F00_0000, 32'h5F00_0000, 1'b0);          // sum of squares is 2^127, still finite
        add_elem(32'h0000_0001, 32'h8000_0001, 1'b0);          // squares underflow
        add_elem(32'h2000_0000, 32'h1F80_0000, 1'b1);          // subnormal square
        add_elem(32'hC040_0000, 32'h4080_0000, 1'b0);
        foreach (m_list[i]) begin
            write_mode(m_list[i]);
            add_elem($urandom, $urandom, 1'b1);
            add_elem($urandom, $urandom, 1'b0);
        end

        // random phases
        sent = 0;
        while (sent < 1800) begin
            case ($urandom_range(9))
                0: m = mmfm_pkg::MODE_BYTE;
                1: m = mmfm_pkg::MODE_USHORT;
                2, 3, 4: m = mmfm_pkg::MODE_CUSHORT;
                5, 6, 7: m = mmfm_pkg::MODE_CFLOAT;
                default: m = 3'($urandom_range(7));
            endcase
            write_mode(m);
            profile = sent * 3 / 1800;
            n = $urandom_range(60, 180);
            repeat (n) begin
                if (m == mmfm_pkg::MODE_CFLOAT)
                    add_elem(rand_float(), rand_float(), 1'($urandom_range(1)));
                else
                    add_elem(rand_short_part(), rand_short_part(), 1'($urandom_range(1)));
            end
            sent += n;
        end
        write_mode(mmfm_pkg::MODE_BYTE);
        wait_idle();

        if (errors == 0) begin
            $display("map_mode_to_float_magnitude_core_tb: clean");
        end else begin
            $display("map_mode_to_float_magnitude_core_tb: errors");
        end
        $finish;
    end

endmodule
